FILE: rtl/i2cram_pkg.sv
package i2cram_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_DATA  = 2'd3;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_START_W   = 4'd1;
   localparam logic [3:0] ST_SEND_DEVW = 4'd2;
   localparam logic [3:0] ST_ACK_DEVW  = 4'd3;
   localparam logic [3:0] ST_SEND_WORD = 4'd4;
   localparam logic [3:0] ST_ACK_WORD  = 4'd5;
   localparam logic [3:0] ST_WAIT      = 4'd6;
   localparam logic [3:0] ST_SEND_DATA = 4'd7;
   localparam logic [3:0] ST_ACK_DATA  = 4'd8;
   localparam logic [3:0] ST_START_R   = 4'd9;
   localparam logic [3:0] ST_SEND_DEVR = 4'd10;
   localparam logic [3:0] ST_ACK_DEVR  = 4'd11;
   localparam logic [3:0] ST_RECV      = 4'd12;
   localparam logic [3:0] ST_MACK      = 4'd13;
   localparam logic [3:0] ST_STOP      = 4'd14;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ADDR_NAK = 2'd1;
   localparam logic [1:0] STAT_WORD_NAK = 2'd2;
   localparam logic [1:0] STAT_DATA_NAK = 2'd3;

   localparam logic [7:0] RETRY_RESET = 8'd100;
   localparam logic [7:0] WRITE_MASK  = 8'hFE;
   localparam logic [7:0] READ_BIT    = 8'h01;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] length;
      logic [7:0] write_data;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       need_data;
      logic       read_valid;
      logic [7:0] read_data;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] byte_count;
   } rsp_type;

endpackage

FILE: rtl/i2c_register_access_master.sv
// Channel  | Direction | Handshake            | Beat payload
// req      | in        | req_valid/req_ready  | cmd, addresses, length, write byte, SDA sample
// rsp      | out       | rsp_valid/rsp_ready  | line levels, status flags, read byte, count
// csr      | in        | csr_write_enable     | retry_limit, written at once, no wait
//
// Each beat is held in the input register and then passes once through the phase update
// logic into the result register; one beat per cycle unless a stalled result holds it back.
// The rate is set by the state update of the bus sequencer, which it makes once per beat.
// Synchronous active-high reset clears both stage valids and the sequencer to idle
// with lines released; retry_limit returns to 100.
// A stalled result holds the input register; req_ready drops only when both are full.
module i2c_register_access_master
   import i2cram_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_dev_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_length,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_need_data,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_byte_count,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    accept;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign accept      = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.cmd        <= req_cmd;
         in_ff.dev_addr   <= req_dev_addr;
         in_ff.reg_addr   <= req_reg_addr;
         in_ff.length     <= req_length;
         in_ff.write_data <= req_write_data;
         in_ff.sda_sample <= req_sda_sample;
      end
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   i2cram_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .step_req         (in_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step_rsp         (step_rsp)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_scl_level  = out_ff.scl_level;
   assign rsp_sda_level  = out_ff.sda_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_need_data  = out_ff.need_data;
   assign rsp_read_valid = out_ff.read_valid;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_status     = out_ff.status;
   assign rsp_byte_count = out_ff.byte_count;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && rsp_scl_level && rsp_sda_level)
      else $error("done beat with engine still busy or lines held");

   a_need_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_need_data |-> rsp_busy_res)
      else $error("waiting for write byte outside a transaction");

   a_read_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> !rsp_done_res && rsp_busy_res)
      else $error("read byte presented outside a busy transaction");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == STAT_OK && rsp_byte_count == 8'd0)
      else $error("status or count reported without done");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("pending beat lost while result stalled");
`endif

endmodule

FILE: rtl/i2cram_core.sv
module i2cram_core
   import i2cram_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  req_type    step_req,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output rsp_type    step_rsp
);

   logic [7:0] retry_ff;
   logic [3:0] seq_ff,     seq_in;
   logic [1:0] phase_ff,   phase_in;
   logic [3:0] idx_ff,     idx_in;
   logic [7:0] shift_ff,   shift_in;
   logic [7:0] attempt_ff, attempt_in;
   logic [7:0] count_ff,   count_in;
   logic [7:0] total_ff,   total_in;
   logic       rd_ff,      rd_in;
   logic [7:0] dev_ff,     dev_in;
   logic [7:0] reg_ff,     reg_in;
   logic [7:0] held_ff,    held_in;
   logic       hvalid_ff,  hvalid_in;
   logic [1:0] estat_ff,   estat_in;
   logic       scl_ff,     scl_in;
   logic       sda_ff,     sda_in;

   logic [3:0] s;
   logic [7:0] lim;
   logic       rvalid;
   logic [7:0] rdata;
   logic       done;
   logic [1:0] ostat;
   logic [7:0] ocount;
   logic       last;

   always_comb begin
      seq_in     = seq_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      shift_in   = shift_ff;
      attempt_in = attempt_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      rd_in      = rd_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      held_in    = held_ff;
      hvalid_in  = hvalid_ff;
      estat_in   = estat_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      rvalid     = 1'b0;
      rdata      = '0;
      done       = 1'b0;
      ostat      = STAT_OK;
      ocount     = '0;
      lim        = (retry_ff == '0) ? 8'd1 : retry_ff;
      last       = 1'b0;
      s          = seq_ff;

      if (seq_ff > ST_STOP) begin
         seq_in   = ST_IDLE;
         phase_in = '0;
         idx_in   = '0;
         s        = ST_IDLE;
      end

      if (step_req.cmd == CMD_DATA) begin
         held_in   = step_req.write_data;
         hvalid_in = 1'b1;
      end else if (step_req.cmd != CMD_TICK) begin
         if (s == ST_IDLE) begin
            dev_in     = step_req.dev_addr;
            reg_in     = step_req.reg_addr;
            total_in   = step_req.length;
            rd_in      = (step_req.cmd == CMD_READ);
            count_in   = '0;
            attempt_in = '0;
            estat_in   = STAT_OK;
            hvalid_in  = 1'b0;
            seq_in     = ST_START_W;
            phase_in   = '0;
            idx_in     = '0;
         end
      end else begin
         if (s == ST_WAIT && hvalid_ff) begin
            shift_in  = held_ff;
            hvalid_in = 1'b0;
            seq_in    = ST_SEND_DATA;
            phase_in  = '0;
            idx_in    = '0;
            s         = ST_SEND_DATA;
         end
         case (s)
            ST_START_W, ST_START_R: begin
               scl_in = (phase_in != 2'd0);
               sda_in = (phase_in != 2'd2);
               if (phase_in >= 2'd2) begin
                  shift_in = (s == ST_START_W) ? (dev_in & WRITE_MASK) : (dev_in | READ_BIT);
                  seq_in   = s + 4'd1;
                  phase_in = '0;
                  idx_in   = '0;
               end else begin
                  phase_in = phase_in + 2'd1;
               end
            end
            ST_SEND_DEVW, ST_SEND_WORD, ST_SEND_DATA, ST_SEND_DEVR: begin
               scl_in = (phase_in != 2'd0);
               sda_in = shift_in[7];
               if (phase_in == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  shift_in = {shift_in[6:0], 1'b0};
                  phase_in = '0;
                  idx_in   = idx_in + 4'd1;
                  if (idx_in >= BITS_PER_BYTE) begin
                     seq_in   = s + 4'd1;
                     phase_in = '0;
                     idx_in   = '0;
                  end
               end
            end
            ST_ACK_DEVW, ST_ACK_WORD, ST_ACK_DATA, ST_ACK_DEVR: begin
               scl_in = (phase_in != 2'd0);
               sda_in = 1'b1;
               if (phase_in == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  phase_in = '0;
                  idx_in   = '0;
                  if (s == ST_ACK_DATA && !step_req.sda_sample) begin
                     count_in = count_in + 8'd1;
                  end
                  if ((s == ST_ACK_DEVW || s == ST_ACK_DEVR) && step_req.sda_sample) begin
                     attempt_in = attempt_in + 8'd1;
                     if (attempt_in >= lim) begin
                        estat_in = STAT_ADDR_NAK;
                        seq_in   = ST_STOP;
                     end else begin
                        seq_in = (s == ST_ACK_DEVW) ? ST_START_W : ST_START_R;
                     end
                  end else if (s == ST_ACK_DEVW) begin
                     shift_in = reg_in;
                     seq_in   = ST_SEND_WORD;
                  end else if (s == ST_ACK_WORD && step_req.sda_sample) begin
                     estat_in = STAT_WORD_NAK;
                     seq_in   = ST_STOP;
                  end else if (s == ST_ACK_DATA && step_req.sda_sample) begin
                     estat_in = STAT_DATA_NAK;
                     seq_in   = ST_STOP;
                  end else if (s == ST_ACK_WORD && rd_in) begin
                     attempt_in = '0;
                     seq_in     = ST_START_R;
                  end else if (s == ST_ACK_DEVR) begin
                     if (total_in == '0) begin
                        estat_in = STAT_OK;
                        seq_in   = ST_STOP;
                     end else begin
                        shift_in = '0;
                        seq_in   = ST_RECV;
                     end
                  end else begin
                     if (count_in == total_in) begin
                        estat_in = STAT_OK;
                        seq_in   = ST_STOP;
                     end else if (hvalid_in) begin
                        shift_in  = held_in;
                        hvalid_in = 1'b0;
                        seq_in    = ST_SEND_DATA;
                     end else begin
                        seq_in = ST_WAIT;
                     end
                  end
               end
            end
            ST_WAIT: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
            end
            ST_RECV: begin
               scl_in = (phase_in != 2'd0);
               sda_in = 1'b1;
               if (phase_in == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  shift_in = {shift_in[6:0], step_req.sda_sample};
                  phase_in = '0;
                  idx_in   = idx_in + 4'd1;
                  if (idx_in >= BITS_PER_BYTE) begin
                     rvalid   = 1'b1;
                     rdata    = shift_in;
                     count_in = count_in + 8'd1;
                     seq_in   = ST_MACK;
                     idx_in   = '0;
                  end
               end
            end
            ST_MACK: begin
               last   = (count_in == total_in);
               scl_in = (phase_in != 2'd0);
               sda_in = last;
               if (phase_in == 2'd0) begin
                  phase_in = 2'd1;
               end else begin
                  phase_in = '0;
                  idx_in   = '0;
                  if (last) begin
                     seq_in = ST_STOP;
                  end else begin
                     shift_in = '0;
                     seq_in   = ST_RECV;
                  end
               end
            end
            ST_STOP: begin
               scl_in = (phase_in != 2'd0);
               sda_in = (phase_in >= 2'd2);
               if (phase_in >= 2'd2) begin
                  done     = 1'b1;
                  ostat    = estat_in;
                  ocount   = count_in;
                  seq_in   = ST_IDLE;
                  phase_in = '0;
                  idx_in   = '0;
               end else begin
                  phase_in = phase_in + 2'd1;
               end
            end
            default: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
         endcase
      end

      step_rsp.scl_level  = scl_in;
      step_rsp.sda_level  = sda_in;
      step_rsp.busy_res   = (seq_in != ST_IDLE);
      step_rsp.need_data  = (seq_in == ST_WAIT) && !hvalid_in;
      step_rsp.read_valid = rvalid;
      step_rsp.read_data  = rdata;
      step_rsp.done_res   = done;
      step_rsp.status     = ostat;
      step_rsp.byte_count = ocount;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= RETRY_RESET;
      end else if (csr_write_enable) begin
         retry_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= ST_IDLE;
         phase_ff   <= '0;
         idx_ff     <= '0;
         shift_ff   <= '0;
         attempt_ff <= '0;
         count_ff   <= '0;
         total_ff   <= '0;
         rd_ff      <= 1'b0;
         dev_ff     <= '0;
         reg_ff     <= '0;
         held_ff    <= '0;
         hvalid_ff  <= 1'b0;
         estat_ff   <= STAT_OK;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
      end else if (step_en) begin
         seq_ff     <= seq_in;
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         shift_ff   <= shift_in;
         attempt_ff <= attempt_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         rd_ff      <= rd_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         held_ff    <= held_in;
         hvalid_ff  <= hvalid_in;
         estat_ff   <= estat_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
      end
   end

endmodule
